// ===== sv/slp_pkg.sv =====
// Shared types, constants and helper functions of the slew-limited parameter block.
`timescale 1ns / 1ps

package slp_pkg;

    // Field widths, Q16.16 values
    localparam int FRACTION_BITS = 16;
    localparam int VALUE_W       = 32;
    localparam int INC_W         = 31;
    localparam int COUNT_W       = 16;
    localparam int LEVEL_W       = 8;
    localparam int LEVEL_BITS    = 7;
    localparam int CMD_W         = 2;
    localparam int CFG_IDX_W     = 3;

    // Derived widths: increment product, its sum with the target, level times span
    localparam int PROD_W = VALUE_W + COUNT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int NUM_W  = LEVEL_BITS + VALUE_W;
    localparam int QUOT_W = VALUE_W;

    // Pipeline stage positions
    localparam int NUM_STAGES = 6;
    localparam int ST_IN      = 0;
    localparam int ST_PREP    = 1;
    localparam int ST_DIV_A   = 2;
    localparam int ST_DIV_B   = 3;
    localparam int ST_DIV_C   = 4;
    localparam int ST_RESOLVE = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INC  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CC   = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAPID = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT  = 3'd5;

    // Highest controller level
    localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = 7'd127;

    // Register reset values
    localparam logic signed [VALUE_W-1:0] RST_MIN   = 32'sd0;
    localparam logic signed [VALUE_W-1:0] RST_MAX   = 32'sd1 <<< FRACTION_BITS;
    localparam logic [INC_W-1:0]          RST_RAPID = 31'd6554;
    localparam logic [INC_W-1:0]          RST_SLOW  = 31'd655;
    localparam logic [INC_W-1:0]          RST_STEP  = 31'd65;
    localparam logic signed [VALUE_W-1:0] RST_INIT  = 32'sd0;

    // Pipeline control from the top level to the stages
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic                  adv;
        logic                  out_load;
        logic                  reinit;
    } t_pipe_ctl;

    // Register contents plus the ordered range ends
    typedef struct packed {
        logic signed [VALUE_W-1:0] min_v;
        logic signed [VALUE_W-1:0] max_v;
        logic [INC_W-1:0]          rapid;
        logic [INC_W-1:0]          slow;
        logic [INC_W-1:0]          step;
        logic signed [VALUE_W-1:0] init_v;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        logic                      inv;
    } t_cfg;

    // Per-item data that rides alongside the divider
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] tgt;
        logic signed [PROD_W-1:0]  prod;
    } t_side;

    // Saturate a wide signed value to [lo, hi]
    function automatic logic signed [VALUE_W-1:0] sat_range(
        input logic signed [SUM_W-1:0]   v,
        input logic signed [VALUE_W-1:0] lo,
        input logic signed [VALUE_W-1:0] hi
    );
        logic signed [SUM_W-1:0] lo_x;
        logic signed [SUM_W-1:0] hi_x;
        lo_x = SUM_W'(lo);
        hi_x = SUM_W'(hi);
        if (v > hi_x) begin
            sat_range = hi;
        end else if (v < lo_x) begin
            sat_range = lo;
        end else begin
            sat_range = v[VALUE_W-1:0];
        end
    endfunction

    // Target after reset: initial value clamped to the reset range
    localparam logic signed [VALUE_W-1:0] RST_GOAL = sat_range(SUM_W'(RST_INIT), RST_MIN, RST_MAX);

endpackage

// ===== sv/slp_front.sv =====
// Input register and first pipeline stage: products, span and clamped set target.
`timescale 1ns / 1ps

module slp_front (
    input  logic                                i_clk,
    input  slp_pkg::t_pipe_ctl                  i_ctl,
    input  slp_pkg::t_cfg                       i_cfg,
    input  logic [slp_pkg::CMD_W-1:0]           i_command,
    input  logic signed [slp_pkg::VALUE_W-1:0]  i_new_value,
    input  logic signed [slp_pkg::COUNT_W-1:0]  i_step_count,
    input  logic                                i_slow_select,
    input  logic [slp_pkg::LEVEL_W-1:0]         i_cc_level,
    output slp_pkg::t_side                      o_side,
    output logic [slp_pkg::NUM_W-1:0]           o_num,
    output logic                                o_neg
);
    import slp_pkg::*;

    logic [CMD_W-1:0]          r_cmd0;
    logic signed [VALUE_W-1:0] r_new0;
    logic signed [COUNT_W-1:0] r_count0;
    logic                      r_slow0;
    logic [LEVEL_W-1:0]        r_lvl0;

    logic [INC_W-1:0]          inc_mag;
    logic signed [VALUE_W-1:0] inc_s;
    logic [LEVEL_BITS-1:0]     lvl;
    logic signed [VALUE_W:0]   diff;
    logic signed [VALUE_W:0]   diff_abs;

    t_side                     n_side;
    logic [NUM_W-1:0]          n_num;
    logic                      n_neg;
    t_side                     r_side1;
    logic [NUM_W-1:0]          r_num1;
    logic                      r_neg1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_IN]) begin
            r_cmd0   <= i_command;
            r_new0   <= i_new_value;
            r_count0 <= i_step_count;
            r_slow0  <= i_slow_select;
            r_lvl0   <= i_cc_level;
        end
    end

    // Increment product, sign follows the range direction
    always_comb begin
        inc_mag     = r_slow0 ? i_cfg.slow : i_cfg.rapid;
        inc_s       = i_cfg.inv ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
        n_side.cmd  = r_cmd0;
        n_side.prod = PROD_W'(inc_s) * PROD_W'(r_count0);
        n_side.tgt  = sat_range(SUM_W'(r_new0), i_cfg.lo, i_cfg.hi);
    end

    // Level times span magnitude; the sign goes along separately
    always_comb begin
        lvl      = r_lvl0[LEVEL_W-1] ? LEVEL_TOP : r_lvl0[LEVEL_BITS-1:0];
        diff     = {i_cfg.max_v[VALUE_W-1], i_cfg.max_v} - {i_cfg.min_v[VALUE_W-1], i_cfg.min_v};
        n_neg    = diff[VALUE_W];
        diff_abs = n_neg ? -diff : diff;
        n_num    = NUM_W'(lvl) * NUM_W'(diff_abs[VALUE_W-1:0]);
    end

    // First stage register
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_PREP]) begin
            r_side1 <= n_side;
            r_num1  <= n_num;
            r_neg1  <= n_neg;
        end
    end

    assign o_side = r_side1;
    assign o_num  = r_num1;
    assign o_neg  = r_neg1;

endmodule

// ===== sv/slp_div127.sv =====
// Three-stage pipelined divide by 127 using base-128 digit folding.
`timescale 1ns / 1ps

module slp_div127 (
    input  logic                              i_clk,
    input  slp_pkg::t_pipe_ctl                i_ctl,
    input  logic [slp_pkg::NUM_W-1:0]         i_num,
    input  logic                              i_neg,
    output logic [slp_pkg::QUOT_W-1:0]        o_quot,
    output logic                              o_neg
);
    import slp_pkg::*;

    // Since 128 = 127 + 1, m / 127 = (m >> 7) + ((m >> 7) + (m & 127)) / 127.
    // Each fold shrinks the remainder by seven bits; widths below follow the bounds.

    logic [31:0] h1;
    logic [32:0] m1;
    logic [25:0] h2;
    logic [25:0] n_m2;
    logic [31:0] n_q2;
    logic [25:0] r_m2;
    logic [31:0] r_q2;
    logic        r_neg2;

    logic [18:0] h3;
    logic [18:0] m3;
    logic [11:0] h4;
    logic [11:0] n_m4;
    logic [31:0] n_q4;
    logic [11:0] r_m4;
    logic [31:0] r_q4;
    logic        r_neg3;

    logic [4:0]  h5;
    logic [7:0]  m5;
    logic        corr;
    logic [31:0] n_q5;
    logic [31:0] r_q5;
    logic        r_neg4;

    // Folds one and two
    always_comb begin
        h1   = i_num[NUM_W-1:7];
        m1   = {1'b0, h1} + 33'(i_num[6:0]);
        h2   = m1[32:7];
        n_m2 = h2 + 26'(m1[6:0]);
        n_q2 = h1 + 32'(h2);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_DIV_A]) begin
            r_m2   <= n_m2;
            r_q2   <= n_q2;
            r_neg2 <= i_neg;
        end
    end

    // Folds three and four
    always_comb begin
        h3   = r_m2[25:7];
        m3   = h3 + 19'(r_m2[6:0]);
        h4   = m3[18:7];
        n_m4 = h4 + 12'(m3[6:0]);
        n_q4 = r_q2 + 32'(h3) + 32'(h4);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_DIV_B]) begin
            r_m4   <= n_m4;
            r_q4   <= n_q4;
            r_neg3 <= r_neg2;
        end
    end

    // Last fold leaves at most 143, so one compare finishes the quotient
    always_comb begin
        h5   = r_m4[11:7];
        m5   = {3'b0, h5} + {1'b0, r_m4[6:0]};
        corr = (m5 >= {1'b0, LEVEL_TOP});
        n_q5 = r_q4 + 32'(h5) + 32'(corr);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_DIV_C]) begin
            r_q5   <= n_q5;
            r_neg4 <= r_neg3;
        end
    end

    assign o_quot = r_q5;
    assign o_neg  = r_neg4;

endmodule

// ===== sv/slp_track.sv =====
// Target resolve stage, value/target state update and result register.
`timescale 1ns / 1ps

module slp_track (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  slp_pkg::t_pipe_ctl                  i_ctl,
    input  slp_pkg::t_cfg                       i_cfg,
    input  slp_pkg::t_side                      i_side,
    input  logic [slp_pkg::QUOT_W-1:0]          i_quot,
    input  logic                                i_neg,
    output logic signed [slp_pkg::VALUE_W-1:0]  o_current_value,
    output logic signed [slp_pkg::VALUE_W-1:0]  o_target_value,
    output logic                                o_changed,
    output logic                                o_dirty
);
    import slp_pkg::*;

    logic signed [VALUE_W+1:0] quot_s;
    logic signed [VALUE_W+1:0] cc_sum;
    logic signed [VALUE_W-1:0] n_tgt5;
    logic [CMD_W-1:0]          r_cmd5;
    logic signed [VALUE_W-1:0] r_tgt5;
    logic signed [PROD_W-1:0]  r_prod5;

    logic signed [VALUE_W-1:0] r_now;
    logic signed [VALUE_W-1:0] r_goal;
    logic                      r_touched;
    logic signed [VALUE_W-1:0] n_now;
    logic signed [VALUE_W-1:0] n_goal;
    logic                      n_touched;
    logic                      n_changed;

    logic signed [VALUE_W+1:0] now_x;
    logic signed [VALUE_W+1:0] goal_x;
    logic signed [VALUE_W+1:0] step_x;
    logic signed [VALUE_W+1:0] up_v;
    logic signed [VALUE_W+1:0] dn_v;
    logic signed [VALUE_W-1:0] tick_now;
    logic signed [SUM_W-1:0]   inc_sum;

    logic signed [VALUE_W-1:0] r_cur;
    logic signed [VALUE_W-1:0] r_tgt;
    logic                      r_changed;
    logic                      r_dirty;

    // Controller target: min plus signed quotient, always inside the range
    always_comb begin
        quot_s = i_neg ? -$signed({2'b0, i_quot}) : $signed({2'b0, i_quot});
        cc_sum = (VALUE_W + 2)'(i_cfg.min_v) + quot_s;
        n_tgt5 = (i_side.cmd == CMD_CC) ? cc_sum[VALUE_W-1:0] : i_side.tgt;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_RESOLVE]) begin
            r_cmd5  <= i_side.cmd;
            r_tgt5  <= n_tgt5;
            r_prod5 <= i_side.prod;
        end
    end

    // One step toward the target, stopping on it
    always_comb begin
        now_x  = (VALUE_W + 2)'(r_now);
        goal_x = (VALUE_W + 2)'(r_goal);
        step_x = $signed({3'b0, i_cfg.step});
        up_v   = now_x + step_x;
        dn_v   = now_x - step_x;
        if (goal_x > now_x) begin
            tick_now = (up_v > goal_x) ? r_goal : up_v[VALUE_W-1:0];
        end else begin
            tick_now = (dn_v < goal_x) ? r_goal : dn_v[VALUE_W-1:0];
        end
        inc_sum = SUM_W'(r_goal) + SUM_W'(r_prod5);
    end

    // Next state per command
    always_comb begin
        n_now     = r_now;
        n_goal    = r_goal;
        n_touched = r_touched;
        n_changed = 1'b0;
        unique case (r_cmd5)
            CMD_TICK: begin
                if (r_now != r_goal) begin
                    n_now     = tick_now;
                    n_changed = 1'b1;
                end
            end
            CMD_SET: begin
                n_goal = r_tgt5;
            end
            CMD_INC: begin
                n_goal    = sat_range(inc_sum, i_cfg.lo, i_cfg.hi);
                n_touched = 1'b1;
            end
            CMD_CC: begin
                n_goal    = r_tgt5;
                n_touched = 1'b1;
            end
        endcase
    end

    // State: reset, re-initialise after a register write, or take the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= RST_MIN;
            r_goal    <= RST_GOAL;
            r_touched <= 1'b0;
        end else if (i_ctl.reinit) begin
            r_now     <= i_cfg.min_v;
            r_goal    <= sat_range(SUM_W'(i_cfg.init_v), i_cfg.lo, i_cfg.hi);
            r_touched <= 1'b0;
        end else if (i_ctl.adv) begin
            r_now     <= n_now;
            r_goal    <= n_goal;
            r_touched <= n_touched;
        end
    end

    // Result register, held while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_cur     <= n_now;
            r_tgt     <= n_goal;
            r_changed <= n_changed;
            r_dirty   <= n_touched;
        end
    end

    assign o_current_value = r_cur;
    assign o_target_value  = r_tgt;
    assign o_changed       = r_changed;
    assign o_dirty         = r_dirty;

`ifndef ASSERT_OFF
    a_changed_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.adv && r_cmd5 != CMD_TICK) |=> !r_changed)
        else $error("changed flagged for a non-tick command");

    a_tick_keeps_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.adv && !i_ctl.reinit && r_cmd5 == CMD_TICK) |=> (r_goal == $past(r_goal)))
        else $error("tick altered the target");

    a_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.adv && !i_ctl.reinit && r_cmd5 == CMD_TICK && r_goal >= r_now)
        |=> (r_now <= r_goal))
        else $error("tick overshot the target");

    a_dirty_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_touched && !i_ctl.reinit) |=> r_touched)
        else $error("dirty flag cleared without a register write");
`endif

endmodule

// ===== sv/slew_limited_parameter.sv =====
// Slew-limited parameter: top level with registers, pipeline control and stages.
// Path: input, prep, divider A-C, resolve and result registers.
// Throughput: one item per cycle unless stalled, bound by the value/target loop.
// Reset (synchronous, active low) restores register defaults and the state.
// A register write re-initialises value and target on the following edge.
`timescale 1ns / 1ps

module slew_limited_parameter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [slp_pkg::CMD_W-1:0]             i_command,
    input  logic signed [slp_pkg::VALUE_W-1:0]    i_new_value,
    input  logic signed [slp_pkg::COUNT_W-1:0]    i_step_count,
    input  logic                                  i_slow_select,
    input  logic [slp_pkg::LEVEL_W-1:0]           i_cc_level,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [slp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [slp_pkg::VALUE_W-1:0]           i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [slp_pkg::VALUE_W-1:0]    o_current_value,
    output logic signed [slp_pkg::VALUE_W-1:0]    o_target_value,
    output logic                                  o_changed,
    output logic                                  o_dirty
);
    import slp_pkg::*;

    logic signed [VALUE_W-1:0] r_min;
    logic signed [VALUE_W-1:0] r_max;
    logic [INC_W-1:0]          r_rapid;
    logic [INC_W-1:0]          r_slow;
    logic [INC_W-1:0]          r_step;
    logic signed [VALUE_W-1:0] r_init;
    logic                      r_reinit;

    logic [NUM_STAGES-1:0]     r_vld;
    logic                      r_out_vld;
    logic [NUM_STAGES-1:0]     rdy;
    logic                      rdy_out;

    t_pipe_ctl                 ctl;
    t_cfg                      cfg;
    t_side                     side1;
    t_side                     r_side2;
    t_side                     r_side3;
    t_side                     r_side4;
    logic [NUM_W-1:0]          num1;
    logic                      neg1;
    logic [QUOT_W-1:0]         quot4;
    logic                      neg4;

    // Register port, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= RST_MIN;
            r_max    <= RST_MAX;
            r_rapid  <= RST_RAPID;
            r_slow   <= RST_SLOW;
            r_step   <= RST_STEP;
            r_init   <= RST_INIT;
            r_reinit <= 1'b0;
        end else begin
            r_reinit <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MIN: begin
                        r_min    <= $signed(i_cfg_data);
                        r_reinit <= 1'b1;
                    end
                    REG_MAX: begin
                        r_max    <= $signed(i_cfg_data);
                        r_reinit <= 1'b1;
                    end
                    REG_RAPID: begin
                        r_rapid  <= i_cfg_data[INC_W-1:0];
                        r_reinit <= 1'b1;
                    end
                    REG_SLOW: begin
                        r_slow   <= i_cfg_data[INC_W-1:0];
                        r_reinit <= 1'b1;
                    end
                    REG_STEP: begin
                        r_step   <= i_cfg_data[INC_W-1:0];
                        r_reinit <= 1'b1;
                    end
                    REG_INIT: begin
                        r_init   <= $signed(i_cfg_data);
                        r_reinit <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Register view with the range ends put in order
    always_comb begin
        cfg.min_v  = r_min;
        cfg.max_v  = r_max;
        cfg.rapid  = r_rapid;
        cfg.slow   = r_slow;
        cfg.step   = r_step;
        cfg.init_v = r_init;
        cfg.inv    = (r_max < r_min);
        cfg.lo     = cfg.inv ? r_max : r_min;
        cfg.hi     = cfg.inv ? r_min : r_max;
    end

    // Stage ready chain: a stage loads when empty or when its successor moves on
    always_comb begin
        rdy_out = !r_out_vld || !i_out_stall;
        rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || rdy_out;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        ctl.load     = rdy;
        ctl.adv      = r_vld[ST_RESOLVE] && rdy_out;
        ctl.out_load = rdy_out;
        ctl.reinit   = r_reinit;
    end

    assign o_in_stall  = !rdy[ST_IN];
    assign o_out_valid = r_out_vld;

    // Valid bits per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (rdy[ST_IN]) begin
                r_vld[ST_IN] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (rdy_out) begin
                r_out_vld <= r_vld[NUM_STAGES-1];
            end
        end
    end

    // Side data follows the divider stages
    always_ff @(posedge i_clk) begin
        if (rdy[ST_DIV_A]) begin
            r_side2 <= side1;
        end
        if (rdy[ST_DIV_B]) begin
            r_side3 <= r_side2;
        end
        if (rdy[ST_DIV_C]) begin
            r_side4 <= r_side3;
        end
    end

    slp_front u_front (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_cfg         (cfg),
        .i_command     (i_command),
        .i_new_value   (i_new_value),
        .i_step_count  (i_step_count),
        .i_slow_select (i_slow_select),
        .i_cc_level    (i_cc_level),
        .o_side        (side1),
        .o_num         (num1),
        .o_neg         (neg1)
    );

    slp_div127 u_div (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_num  (num1),
        .i_neg  (neg1),
        .o_quot (quot4),
        .o_neg  (neg4)
    );

    slp_track u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_cfg           (cfg),
        .i_side          (r_side4),
        .i_quot          (quot4),
        .i_neg           (neg4),
        .o_current_value (o_current_value),
        .o_target_value  (o_target_value),
        .o_changed       (o_changed),
        .o_dirty         (o_dirty)
    );

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&r_vld) && r_out_vld && i_out_stall))
        else $error("input stalled while the pipeline had room");
`endif

endmodule
